/* rtl/core/mst_pkg.sv */
// Shared constants, payload types and control types for the matrix store unit.
package mst_pkg;

    localparam int MAX_DIM = 16;
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * DIM_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int CNT_W   = 5;
    localparam int VAL_W   = 31;
    localparam int IDX_W   = 16;
    localparam int KIND_W  = 3;

    localparam logic [KIND_W-1:0] KIND_INIT      = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_GET       = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_SET       = KIND_W'(2);
    localparam logic [KIND_W-1:0] KIND_TRANSPOSE = KIND_W'(3);
    localparam logic [KIND_W-1:0] KIND_SWAP      = KIND_W'(4);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  first;
        logic [IDX_W-1:0]  second;
        logic [VAL_W-1:0]  value;
    } t_in;

    typedef struct packed {
        logic              status;
        logic [VAL_W-1:0]  read_value;
        logic [CNT_W-1:0]  rows_now;
        logic [CNT_W-1:0]  cols_now;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_GET,
        S_SET,
        S_PAIR_RD,
        S_PAIR_WA,
        S_PAIR_WB,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        WSEL_ZERO,
        WSEL_VALUE,
        WSEL_RD0,
        WSEL_RD1
    } t_wsel;

    typedef enum logic [1:0] {
        OSEL_ZERO,
        OSEL_VALUE,
        OSEL_RD0
    } t_osel;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_wsel             wsel;
        logic [VAL_W-1:0]  wvalue;
        logic              re;
        logic [ADDR_W-1:0] raddr0;
        logic [ADDR_W-1:0] raddr1;
        logic              set_dims;
        logic              swap_dims;
        logic [CNT_W-1:0]  dim_rows;
        logic [CNT_W-1:0]  dim_cols;
        logic              load_out;
        logic              out_fail;
        t_osel             osel;
    } t_cmd;

    typedef struct packed {
        logic              initialized;
        logic [CNT_W-1:0]  rows;
        logic [CNT_W-1:0]  cols;
        logic              out_free;
    } t_stat;

endpackage

/* rtl/core/matrix_store_transpose_swap_unit.sv */
// Top level of the matrix store with get, set, transpose and row swap commands.
//
// One command enters on the input channel (i_in_valid / o_in_ready, payload i_in)
// and exactly one result leaves on the output channel (o_out_valid / i_out_ready,
// payload o_out) per command. Commands are handled one at a time.
// Work done between input transfer and result valid:
//   rejected command or bad index : none
//   get                           : one memory read
//   set                           : one memory write
//   init                          : clears all 256 words
//   row swap                      : read, write, write for each of 16 columns
//   transpose                     : read, write, write for each of 120 pairs
// Each moved word is written separately through the single write port of the
// element memory. The controller returns to idle in the cycle after the result
// is loaded, and only there takes the next command.
// The result sits in an output register: a new command is accepted while it
// waits, as long as it leaves no later than the acceptance cycle.
// Reset clears the dimensions and the initialized flag; the memory is cleared by
// the first init, and every other command is rejected until then.
module matrix_store_transpose_swap_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mst_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mst_pkg::t_out o_out
);

    mst_pkg::t_cmd  cmd;
    mst_pkg::t_stat stat;

    mst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mst_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

/* rtl/core/mst_dpath.sv */
// Datapath: element memory, read registers, matrix dimensions and result register.
module mst_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mst_pkg::t_cmd  i_cmd,
    output mst_pkg::t_stat o_stat,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mst_pkg::t_out  o_out
);

    logic [mst_pkg::VAL_W-1:0] mem [mst_pkg::DEPTH];
    logic [mst_pkg::VAL_W-1:0] r_rd0;
    logic [mst_pkg::VAL_W-1:0] r_rd1;
    logic [mst_pkg::CNT_W-1:0] r_rows;
    logic [mst_pkg::CNT_W-1:0] r_cols;
    logic                      r_init;
    mst_pkg::t_out             r_out;
    logic                      r_out_valid;
    logic [mst_pkg::VAL_W-1:0] wdata;
    logic [mst_pkg::VAL_W-1:0] oval;

    always_comb begin
        case (i_cmd.wsel)
            mst_pkg::WSEL_ZERO:  wdata = '0;
            mst_pkg::WSEL_VALUE: wdata = i_cmd.wvalue;
            mst_pkg::WSEL_RD0:   wdata = r_rd0;
            mst_pkg::WSEL_RD1:   wdata = r_rd1;
            default:             wdata = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.osel)
            mst_pkg::OSEL_VALUE: oval = i_cmd.wvalue;
            mst_pkg::OSEL_RD0:   oval = r_rd0;
            default:             oval = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            mem[i_cmd.waddr] <= wdata;
        end
        if (i_cmd.re) begin
            r_rd0 <= mem[i_cmd.raddr0];
            r_rd1 <= mem[i_cmd.raddr1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '0;
            r_cols <= '0;
            r_init <= 1'b0;
        end else if (i_cmd.set_dims) begin
            r_rows <= i_cmd.dim_rows;
            r_cols <= i_cmd.dim_cols;
            r_init <= 1'b1;
        end else if (i_cmd.swap_dims) begin
            r_rows <= r_cols;
            r_cols <= r_rows;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.status     <= i_cmd.out_fail;
            r_out.read_value <= oval;
            r_out.rows_now   <= r_rows;
            r_out.cols_now   <= r_cols;
        end
    end

    assign o_stat.initialized = r_init;
    assign o_stat.rows        = r_rows;
    assign o_stat.cols        = r_cols;
    assign o_stat.out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out              = r_out;

endmodule

/* rtl/core/mst_ctrl.sv */
// Controller: command decode, range checks, sequencing of clear, mirror and row swap.
module mst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mst_pkg::t_in   i_in,
    input  mst_pkg::t_stat i_stat,
    output mst_pkg::t_cmd  o_cmd
);

    localparam logic [mst_pkg::DIM_W-1:0] LAST = mst_pkg::DIM_W'(mst_pkg::MAX_DIM - 1);
    localparam logic [mst_pkg::DIM_W-1:0] PENULT = mst_pkg::DIM_W'(mst_pkg::MAX_DIM - 2);

    mst_pkg::t_state            r_state;
    mst_pkg::t_state            n_state;
    logic [mst_pkg::KIND_W-1:0] r_kind;
    logic [mst_pkg::KIND_W-1:0] n_kind;
    logic                       r_fail;
    logic                       n_fail;
    logic [mst_pkg::DIM_W-1:0]  r_a;
    logic [mst_pkg::DIM_W-1:0]  n_a;
    logic [mst_pkg::DIM_W-1:0]  r_b;
    logic [mst_pkg::DIM_W-1:0]  n_b;
    logic [mst_pkg::VAL_W-1:0]  r_value;
    logic [mst_pkg::VAL_W-1:0]  n_value;
    logic [mst_pkg::DIM_W-1:0]  r_i;
    logic [mst_pkg::DIM_W-1:0]  n_i;
    logic [mst_pkg::DIM_W-1:0]  r_j;
    logic [mst_pkg::DIM_W-1:0]  n_j;

    logic                       accept;
    logic                       first_row_ok;
    logic                       second_col_ok;
    logic                       second_row_ok;
    logic                       size_ok;
    logic                       cmd_ok;
    logic                       mirror;
    logic                       last_pair;
    logic                       last_cell;
    logic [mst_pkg::ADDR_W-1:0] p0;
    logic [mst_pkg::ADDR_W-1:0] p1;

    assign accept = i_in_valid && o_in_ready;

    assign first_row_ok  = (i_in.first != '0)
                        && (i_in.first <= mst_pkg::IDX_W'(i_stat.rows));
    assign second_col_ok = (i_in.second != '0)
                        && (i_in.second <= mst_pkg::IDX_W'(i_stat.cols));
    assign second_row_ok = (i_in.second != '0)
                        && (i_in.second <= mst_pkg::IDX_W'(i_stat.rows));
    assign size_ok = (i_in.first >= mst_pkg::IDX_W'(2))
                  && (i_in.first <= mst_pkg::IDX_W'(mst_pkg::MAX_DIM))
                  && (i_in.second >= mst_pkg::IDX_W'(2))
                  && (i_in.second <= mst_pkg::IDX_W'(mst_pkg::MAX_DIM));

    always_comb begin
        case (i_in.kind)
            mst_pkg::KIND_INIT:      cmd_ok = size_ok;
            mst_pkg::KIND_GET,
            mst_pkg::KIND_SET:       cmd_ok = i_stat.initialized && first_row_ok
                                           && second_col_ok;
            mst_pkg::KIND_TRANSPOSE: cmd_ok = i_stat.initialized;
            mst_pkg::KIND_SWAP:      cmd_ok = i_stat.initialized && first_row_ok
                                           && second_row_ok;
            default:                 cmd_ok = 1'b0;
        endcase
    end

    assign mirror    = (r_kind == mst_pkg::KIND_TRANSPOSE);
    assign last_pair = mirror ? ((r_i == PENULT) && (r_j == LAST)) : (r_j == LAST);
    assign last_cell = (r_i == LAST) && (r_j == LAST);
    assign p0 = mirror ? {r_i, r_j} : {r_a, r_j};
    assign p1 = mirror ? {r_j, r_i} : {r_b, r_j};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mst_pkg::S_IDLE: begin
                if (accept) begin
                    if (!cmd_ok) begin
                        n_state = mst_pkg::S_DONE;
                    end else begin
                        case (i_in.kind)
                            mst_pkg::KIND_INIT:      n_state = mst_pkg::S_CLEAR;
                            mst_pkg::KIND_GET:       n_state = mst_pkg::S_GET;
                            mst_pkg::KIND_SET:       n_state = mst_pkg::S_SET;
                            mst_pkg::KIND_TRANSPOSE,
                            mst_pkg::KIND_SWAP:      n_state = mst_pkg::S_PAIR_RD;
                            default:                 n_state = mst_pkg::S_DONE;
                        endcase
                    end
                end
            end
            mst_pkg::S_CLEAR: begin
                if (last_cell) begin
                    n_state = mst_pkg::S_DONE;
                end
            end
            mst_pkg::S_GET:     n_state = mst_pkg::S_DONE;
            mst_pkg::S_SET:     n_state = mst_pkg::S_DONE;
            mst_pkg::S_PAIR_RD: n_state = mst_pkg::S_PAIR_WA;
            mst_pkg::S_PAIR_WA: n_state = mst_pkg::S_PAIR_WB;
            mst_pkg::S_PAIR_WB: n_state = last_pair ? mst_pkg::S_DONE : mst_pkg::S_PAIR_RD;
            mst_pkg::S_DONE:    n_state = mst_pkg::S_IDLE;
            default:            n_state = mst_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = (r_state == mst_pkg::S_IDLE) && i_stat.out_free;
        o_cmd          = '0;
        o_cmd.wsel     = mst_pkg::WSEL_ZERO;
        o_cmd.osel     = mst_pkg::OSEL_ZERO;
        o_cmd.wvalue   = r_value;
        o_cmd.dim_rows = mst_pkg::CNT_W'(i_in.first);
        o_cmd.dim_cols = mst_pkg::CNT_W'(i_in.second);
        case (r_state)
            mst_pkg::S_IDLE: begin
                o_cmd.set_dims  = accept && cmd_ok && (i_in.kind == mst_pkg::KIND_INIT);
                o_cmd.swap_dims = accept && cmd_ok && (i_in.kind == mst_pkg::KIND_TRANSPOSE);
            end
            mst_pkg::S_CLEAR: begin
                o_cmd.we    = 1'b1;
                o_cmd.waddr = {r_i, r_j};
                o_cmd.wsel  = mst_pkg::WSEL_ZERO;
            end
            mst_pkg::S_GET: begin
                o_cmd.re     = 1'b1;
                o_cmd.raddr0 = {r_a, r_b};
                o_cmd.raddr1 = {r_a, r_b};
            end
            mst_pkg::S_SET: begin
                o_cmd.we    = 1'b1;
                o_cmd.waddr = {r_a, r_b};
                o_cmd.wsel  = mst_pkg::WSEL_VALUE;
            end
            mst_pkg::S_PAIR_RD: begin
                o_cmd.re     = 1'b1;
                o_cmd.raddr0 = p0;
                o_cmd.raddr1 = p1;
            end
            mst_pkg::S_PAIR_WA: begin
                o_cmd.we    = 1'b1;
                o_cmd.waddr = p0;
                o_cmd.wsel  = mst_pkg::WSEL_RD1;
            end
            mst_pkg::S_PAIR_WB: begin
                o_cmd.we    = 1'b1;
                o_cmd.waddr = p1;
                o_cmd.wsel  = mst_pkg::WSEL_RD0;
            end
            mst_pkg::S_DONE: begin
                o_cmd.load_out = 1'b1;
                o_cmd.out_fail = r_fail;
                if (r_fail) begin
                    o_cmd.osel = mst_pkg::OSEL_ZERO;
                end else if (r_kind == mst_pkg::KIND_GET) begin
                    o_cmd.osel = mst_pkg::OSEL_RD0;
                end else if (r_kind == mst_pkg::KIND_SET) begin
                    o_cmd.osel = mst_pkg::OSEL_VALUE;
                end else begin
                    o_cmd.osel = mst_pkg::OSEL_ZERO;
                end
            end
            default: begin
                o_cmd.load_out = 1'b0;
            end
        endcase
    end

    // command registers and walk counters
    always_comb begin
        n_kind  = r_kind;
        n_fail  = r_fail;
        n_a     = r_a;
        n_b     = r_b;
        n_value = r_value;
        n_i     = r_i;
        n_j     = r_j;
        if (accept) begin
            n_kind  = i_in.kind;
            n_fail  = !cmd_ok;
            n_a     = mst_pkg::DIM_W'(i_in.first - mst_pkg::IDX_W'(1));
            n_b     = mst_pkg::DIM_W'(i_in.second - mst_pkg::IDX_W'(1));
            n_value = i_in.value;
            n_i     = '0;
            n_j     = (i_in.kind == mst_pkg::KIND_TRANSPOSE) ? mst_pkg::DIM_W'(1) : '0;
        end else if (r_state == mst_pkg::S_CLEAR) begin
            {n_i, n_j} = {r_i, r_j} + mst_pkg::ADDR_W'(1);
        end else if (r_state == mst_pkg::S_PAIR_WB) begin
            if (mirror && (r_j == LAST)) begin
                n_i = r_i + mst_pkg::DIM_W'(1);
                n_j = r_i + mst_pkg::DIM_W'(2);
            end else begin
                n_j = r_j + mst_pkg::DIM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mst_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_fail  <= n_fail;
        r_a     <= n_a;
        r_b     <= n_b;
        r_value <= n_value;
        r_i     <= n_i;
        r_j     <= n_j;
    end

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_stat.out_free)
        else $error("result loaded while result register occupied");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mst_pkg::S_IDLE) |-> !o_cmd.we)
        else $error("memory write while idle");

    a_copy_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.we && (o_cmd.wsel == mst_pkg::WSEL_RD1)) |-> $past(o_cmd.re))
        else $error("pair write without preceding read");

    a_init_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.initialized |=> i_stat.initialized)
        else $error("initialized flag dropped");

    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mst_pkg::S_DONE) |=> (r_state == mst_pkg::S_IDLE))
        else $error("controller did not return to idle after result");

endmodule

/* bench/tb_top.sv */
// Testbench for the matrix store unit: directed and random commands checked against a predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 400;
    localparam int IDLE_PCT      = 25;
    localparam int CALM_FROM     = 420;
    localparam int CALM_TO       = 560;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 4;
    localparam int PHASE_ITEMS   = 212;

    localparam logic ST_DONE   = 1'b0;
    localparam logic ST_REJECT = 1'b1;
    localparam logic [mst_pkg::KIND_W-1:0] KIND_SPARE_LO = mst_pkg::KIND_SWAP + 1'b1;
    localparam logic [mst_pkg::KIND_W-1:0] KIND_SPARE_HI = {mst_pkg::KIND_W{1'b1}};
    localparam logic [mst_pkg::VAL_W-1:0]  VAL_MAX       = {mst_pkg::VAL_W{1'b1}};

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_ready;
    mst_pkg::t_in  in_data   = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    mst_pkg::t_out out_data;
    logic          recv_hold = 1'b0;

    mst_pkg::t_in  cmd_queue[$];
    mst_pkg::t_out expected_results[$];

    // predictor state
    logic [mst_pkg::VAL_W-1:0] cell_mem [mst_pkg::DEPTH] = '{default: '0};
    logic [mst_pkg::CNT_W-1:0] mat_rows = '0;
    logic [mst_pkg::CNT_W-1:0] mat_cols = '0;
    logic                      mat_live = 1'b0;

    // dimensions as seen by the generator, one step ahead of the predictor
    logic [mst_pkg::CNT_W-1:0] plan_rows = '0;
    logic [mst_pkg::CNT_W-1:0] plan_cols = '0;
    logic                      plan_live = 1'b0;

    int sent_count  = 0;
    int recv_count  = 0;
    int error_count = 0;
    int cycle_count = 0;

    matrix_store_transpose_swap_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic idx_ok(logic [mst_pkg::IDX_W-1:0] idx,
                                    logic [mst_pkg::CNT_W-1:0] count);
        return idx >= 1 && idx <= count;
    endfunction

    function automatic logic dim_ok(logic [mst_pkg::IDX_W-1:0] n);
        return n >= 2 && n <= mst_pkg::MAX_DIM;
    endfunction

    function automatic mst_pkg::t_out run_matrix_cmd(mst_pkg::t_in cmd);
        mst_pkg::t_out             res;
        logic [mst_pkg::VAL_W-1:0] held;
        logic [mst_pkg::CNT_W-1:0] tmp;
        int                        a;
        int                        b;
        res        = '0;
        res.status = ST_REJECT;
        if (cmd.kind == mst_pkg::KIND_INIT) begin
            if (dim_ok(cmd.first) && dim_ok(cmd.second)) begin
                mat_rows = cmd.first[mst_pkg::CNT_W-1:0];
                mat_cols = cmd.second[mst_pkg::CNT_W-1:0];
                foreach (cell_mem[i]) cell_mem[i] = '0;
                mat_live   = 1'b1;
                res.status = ST_DONE;
            end
        end else if (mat_live) begin
            case (cmd.kind)
                mst_pkg::KIND_GET, mst_pkg::KIND_SET: begin
                    if (idx_ok(cmd.first, mat_rows) && idx_ok(cmd.second, mat_cols)) begin
                        a = (cmd.first - 1) * mst_pkg::MAX_DIM + (cmd.second - 1);
                        if (cmd.kind == mst_pkg::KIND_SET) begin
                            cell_mem[a] = cmd.value;
                        end
                        res.read_value = cell_mem[a];
                        res.status     = ST_DONE;
                    end
                end
                mst_pkg::KIND_TRANSPOSE: begin
                    for (a = 0; a < mst_pkg::MAX_DIM; a++) begin
                        for (b = a + 1; b < mst_pkg::MAX_DIM; b++) begin
                            held = cell_mem[a * mst_pkg::MAX_DIM + b];
                            cell_mem[a * mst_pkg::MAX_DIM + b] =
                                cell_mem[b * mst_pkg::MAX_DIM + a];
                            cell_mem[b * mst_pkg::MAX_DIM + a] = held;
                        end
                    end
                    tmp        = mat_rows;
                    mat_rows   = mat_cols;
                    mat_cols   = tmp;
                    res.status = ST_DONE;
                end
                mst_pkg::KIND_SWAP: begin
                    if (idx_ok(cmd.first, mat_rows) && idx_ok(cmd.second, mat_rows)) begin
                        for (b = 0; b < mst_pkg::MAX_DIM; b++) begin
                            a        = (cmd.first - 1) * mst_pkg::MAX_DIM + b;
                            held     = cell_mem[a];
                            cell_mem[a] = cell_mem[(cmd.second - 1) * mst_pkg::MAX_DIM + b];
                            cell_mem[(cmd.second - 1) * mst_pkg::MAX_DIM + b] = held;
                        end
                        res.status = ST_DONE;
                    end
                end
                default: ;
            endcase
        end
        res.rows_now = mat_rows;
        res.cols_now = mat_cols;
        return res;
    endfunction

    task automatic queue_cmd(logic [mst_pkg::KIND_W-1:0] kind,
                             logic [mst_pkg::IDX_W-1:0] first,
                             logic [mst_pkg::IDX_W-1:0] second,
                             logic [mst_pkg::VAL_W-1:0] value);
        mst_pkg::t_in              cmd;
        logic [mst_pkg::CNT_W-1:0] tmp;
        cmd.kind   = kind;
        cmd.first  = first;
        cmd.second = second;
        cmd.value  = value;
        cmd_queue.insert(cmd_queue.size(), cmd);
        if (kind == mst_pkg::KIND_INIT && dim_ok(first) && dim_ok(second)) begin
            plan_rows = first[mst_pkg::CNT_W-1:0];
            plan_cols = second[mst_pkg::CNT_W-1:0];
            plan_live = 1'b1;
        end else if (kind == mst_pkg::KIND_TRANSPOSE && plan_live) begin
            tmp       = plan_rows;
            plan_rows = plan_cols;
            plan_cols = tmp;
        end
    endtask

    function automatic logic [mst_pkg::IDX_W-1:0] bad_index(logic [mst_pkg::CNT_W-1:0] count);
        case ($urandom_range(0, 2))
            0: return '0;
            1: return mst_pkg::IDX_W'(count) + mst_pkg::IDX_W'($urandom_range(1, 4));
            default: return mst_pkg::IDX_W'($urandom);
        endcase
    endfunction

    task automatic queue_random_cmd();
        int                         pick;
        logic                       coin;
        logic [mst_pkg::KIND_W-1:0] kind;
        logic [mst_pkg::IDX_W-1:0]  r;
        logic [mst_pkg::IDX_W-1:0]  c;
        logic [mst_pkg::IDX_W-1:0]  r2;
        logic [mst_pkg::IDX_W-1:0]  alt;
        logic [mst_pkg::IDX_W-1:0]  bad;
        logic [mst_pkg::CNT_W-1:0]  lim;
        logic [mst_pkg::VAL_W-1:0]  val;
        pick = $urandom_range(0, 99);
        coin = $urandom_range(0, 1);
        r    = mst_pkg::IDX_W'($urandom_range(1, plan_rows));
        c    = mst_pkg::IDX_W'($urandom_range(1, plan_cols));
        r2   = mst_pkg::IDX_W'($urandom_range(1, plan_rows));
        val  = ($urandom_range(0, 9) == 0) ? (coin ? VAL_MAX : '0)
                                           : mst_pkg::VAL_W'($urandom);
        if (!plan_live || pick < 4) begin
            queue_cmd(mst_pkg::KIND_INIT, mst_pkg::IDX_W'($urandom_range(2, mst_pkg::MAX_DIM)),
                      mst_pkg::IDX_W'($urandom_range(2, mst_pkg::MAX_DIM)), val);
        end else if (pick < 7) begin
            bad = coin ? mst_pkg::IDX_W'($urandom_range(0, 1))
                       : mst_pkg::IDX_W'($urandom_range(mst_pkg::MAX_DIM + 1, 65535));
            if ($urandom_range(0, 1)) begin
                queue_cmd(mst_pkg::KIND_INIT, bad,
                          mst_pkg::IDX_W'($urandom_range(2, mst_pkg::MAX_DIM)), val);
            end else begin
                queue_cmd(mst_pkg::KIND_INIT,
                          mst_pkg::IDX_W'($urandom_range(2, mst_pkg::MAX_DIM)), bad, val);
            end
        end else if (pick < 37) begin
            queue_cmd(mst_pkg::KIND_SET, r, c, val);
        end else if (pick < 65) begin
            queue_cmd(mst_pkg::KIND_GET, r, c, val);
        end else if (pick < 71) begin
            queue_cmd(mst_pkg::KIND_TRANSPOSE, mst_pkg::IDX_W'($urandom),
                      mst_pkg::IDX_W'($urandom), val);
        end else if (pick < 84) begin
            queue_cmd(mst_pkg::KIND_SWAP, r, r2, val);
        end else if (pick < 88) begin
            queue_cmd(mst_pkg::KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                      mst_pkg::IDX_W'($urandom), mst_pkg::IDX_W'($urandom), val);
        end else begin
            case ($urandom_range(0, 2))
                0: kind = mst_pkg::KIND_GET;
                1: kind = mst_pkg::KIND_SET;
                default: kind = mst_pkg::KIND_SWAP;
            endcase
            lim = (kind == mst_pkg::KIND_SWAP) ? plan_rows : plan_cols;
            alt = (kind == mst_pkg::KIND_SWAP) ? r2 : c;
            if (coin) begin
                queue_cmd(kind, bad_index(plan_rows), alt, val);
            end else begin
                queue_cmd(kind, r, bad_index(lim), val);
            end
        end
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || in_valid || expected_results.size() != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic report_mismatch(string what);
        error_count++;
        $display("[cycle %0d, result %0d] mismatch: %s", cycle_count, recv_count, what);
    endtask

    // command driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_results.insert(expected_results.size(), run_matrix_cmd(in_data));
                sent_count++;
            end
            if (!in_valid || in_ready) begin
                if (cmd_queue.size() != 0 &&
                    ((sent_count >= CALM_FROM && sent_count < CALM_TO) ||
                     $urandom_range(0, 99) >= IDLE_PCT)) begin
                    in_data  <= cmd_queue.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin : result_check
        mst_pkg::t_out want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                recv_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result transfer with nothing outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  out_data.status, want.status));
                    if (out_data.read_value !== want.read_value)
                        report_mismatch($sformatf("read_value %0h, expected %0h",
                                                  out_data.read_value, want.read_value));
                    if (out_data.rows_now !== want.rows_now)
                        report_mismatch($sformatf("rows_now %0d, expected %0d",
                                                  out_data.rows_now, want.rows_now));
                    if (out_data.cols_now !== want.cols_now)
                        report_mismatch($sformatf("cols_now %0d, expected %0d",
                                                  out_data.cols_now, want.cols_now));
                end
            end
            out_ready <= !recv_hold &&
                         ((recv_count >= CALM_FROM && recv_count < CALM_TO) ||
                          $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // long receiver stall while commands keep coming
    initial begin
        while (sent_count < HOLD_AT) @(negedge clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        recv_hold <= 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int p;
        int n;
        // before init: everything but init is rejected
        queue_cmd(mst_pkg::KIND_GET, 1, 1, '0);
        queue_cmd(mst_pkg::KIND_SET, 1, 1, 5);
        queue_cmd(mst_pkg::KIND_TRANSPOSE, 0, 0, '0);
        queue_cmd(mst_pkg::KIND_SWAP, 1, 2, '0);
        queue_cmd(mst_pkg::KIND_INIT, 1, 16, '0);
        queue_cmd(mst_pkg::KIND_INIT, 16, 17, '0);
        queue_cmd(mst_pkg::KIND_INIT, 16, 16, '0);
        queue_cmd(mst_pkg::KIND_SET, 1, 1, VAL_MAX);
        queue_cmd(mst_pkg::KIND_SET, 16, 16, 31'h2AAA_AAAA);
        queue_cmd(mst_pkg::KIND_GET, 16, 16, '0);
        queue_cmd(mst_pkg::KIND_GET, 0, 1, '0);
        queue_cmd(mst_pkg::KIND_SET, 1, 17, 1);
        queue_cmd(mst_pkg::KIND_GET, 16'hFFFF, 16'hFFFF, '0);
        queue_cmd(mst_pkg::KIND_SWAP, 1, 16, '0);
        queue_cmd(mst_pkg::KIND_GET, 16, 1, '0);
        queue_cmd(mst_pkg::KIND_SWAP, 3, 3, '0);
        queue_cmd(mst_pkg::KIND_SWAP, 2, 17, '0);
        queue_cmd(KIND_SPARE_HI, 16'hFFFF, 16'hFFFF, VAL_MAX);
        // re-init to a non-square shape, then mirror it
        queue_cmd(mst_pkg::KIND_INIT, 2, 16, '0);
        queue_cmd(mst_pkg::KIND_SET, 2, 16, 31'h5555_5555);
        queue_cmd(mst_pkg::KIND_TRANSPOSE, 0, 0, '0);
        queue_cmd(mst_pkg::KIND_GET, 16, 2, '0);
        queue_cmd(mst_pkg::KIND_INIT, 16'hFFFF, 2, '0);
        queue_cmd(mst_pkg::KIND_GET, 16, 2, '0);
        wait_drained();

        for (p = 0; p < PHASES; p++) begin
            for (n = 0; n < PHASE_ITEMS; n++) begin
                queue_random_cmd();
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
